[design/sgf_pkg.sv]
// Shared definitions for the sample gap linear fill block.
// Holds parameter defaults and the sequencer state type; depends on nothing.
`default_nettype none

package sgf_pkg;

	// Default longest gap that is held back for interpolation.
	localparam int unsigned MAX_GAP_DEF = 63;
	// Default sample width, signed fixed point with 8 fraction bits.
	localparam int unsigned SAMPLE_BITS_DEF = 24;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FILL,
		ST_ORIG,
		ST_OVF,
		ST_TAIL
	} state_t;

endpackage

`default_nettype wire

[design/sgf_if.sv]
// Valid/ready channel interfaces for the sample gap linear fill block.
// Depends on sgf_pkg for the default sample width.
`default_nettype none

interface sgf_in_if #(
	parameter int unsigned SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_value;
	logic                          sample_valid;
	logic                          series_end;

	modport source (output valid, sample_value, sample_valid, series_end, input ready);
	modport sink (input valid, sample_value, sample_valid, series_end, output ready);
endinterface

interface sgf_out_if #(
	parameter int unsigned SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] filled_value;
	logic                          was_filled;
	logic                          gap_overflow;
	logic                          run_last;
	logic                          series_done;

	modport source (output valid, filled_value, was_filled, gap_overflow, run_last,
		series_done, input ready);
	modport sink (input valid, filled_value, was_filled, gap_overflow, run_last,
		series_done, output ready);
endinterface

`default_nettype wire

[design/sample_gap_linear_fill.sv]
// Sample gap linear fill: streaming gap filler with a shared iterative divider.
// Depends on sgf_pkg and on the sgf_in_if / sgf_out_if channel interfaces.
//
// Usage: samples enter on sample_in, one transfer per sample, each marked present
// or missing; series_end marks the last sample of a series. Missing samples are
// counted and produce no transfer on fill_out until the run closes. A present
// sample releases the pending gap, filled by linear interpolation (or held at
// the sample when no earlier value is known), followed by the sample itself.
// A series end flushes a trailing gap as held values. A gap that grows past
// MAX_GAP is flushed as held values with gap_overflow set.
// Timing: sample_in is ready only while the sequencer is idle. A missing sample
// that closes nothing leaves it idle. An interpolated gap of length g is accepted,
// then runs the restoring divider (one quotient bit a cycle, one division per gap),
// then gives g+1 results, one result a cycle while the receiver takes them.
// Other runs are accepted and then give their results. run_last marks the
// final result of each sample, series_done the final result of a series.
// A registered output stage holds the current result; when the receiver stalls,
// the sequencer waits with it and resumes as soon as the result is taken.
// Reset clears the series state and the output stage; no clearing pass.
`default_nettype none

module sample_gap_linear_fill #(
	parameter int unsigned MAX_GAP     = sgf_pkg::MAX_GAP_DEF,
	parameter int unsigned SAMPLE_BITS = sgf_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sgf_in_if.sink      sample_in,
	sgf_out_if.source   fill_out
);

	localparam int unsigned GW  = $clog2(MAX_GAP + 1);  // pending count width
	localparam int unsigned DVW = $clog2(MAX_GAP + 2);  // divisor width (g+1)
	localparam int unsigned DW  = SAMPLE_BITS + 1;      // difference magnitude width
	localparam int unsigned CW  = $clog2(DW + 1);       // divide step counter width
	localparam int unsigned XW  = SAMPLE_BITS + 2;      // interpolation sum width

	sgf_pkg::state_t state_q, state_d;

	// Series state.
	logic signed [SAMPLE_BITS-1:0] left_value_q;
	logic                          left_known_q;
	logic [GW-1:0]                 pending_q;

	// Current item and run control.
	logic signed [SAMPLE_BITS-1:0] item_value_q;
	logic                          item_end_q;
	logic                          interp_q;
	logic [GW-1:0]                 cnt_q;
	logic [CW-1:0]                 div_cnt_q;

	// Divider and interpolation accumulator.
	logic                          neg_q;
	logic [DVW-1:0]                divisor_q;
	logic [DW-1:0]                 quo_q;
	logic [DVW-1:0]                rem_q;
	logic [DW-1:0]                 acc_q;
	logic [DVW-1:0]                acc_r_q;

	// Output stage.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic                          out_filled_q;
	logic                          out_ovf_q;
	logic                          out_last_q;
	logic                          out_done_q;

	logic                          accept;
	logic                          emit;
	logic                          load;
	logic signed [SAMPLE_BITS-1:0] res_value;
	logic                          res_filled;
	logic                          res_ovf;
	logic                          res_last;
	logic                          res_done;

	logic signed [DW-1:0]          diff;
	logic [DW-1:0]                 diff_mag;
	logic [DVW:0]                  trial;
	logic                          sub_ok;
	logic [DW-1:0]                 quo_next;
	logic [DVW-1:0]                rem_next;
	logic [DVW:0]                  acc_r_sum;
	logic                          acc_carry;
	logic signed [XW-1:0]          interp_sum;
	logic                          gap_full;

	assign sample_in.ready = (state_q == sgf_pkg::ST_IDLE);
	assign accept          = sample_in.valid && sample_in.ready;
	assign gap_full        = (pending_q == GW'(MAX_GAP));

	// Difference to the new right value and its magnitude.
	assign diff     = DW'(sample_in.sample_value) - DW'(left_value_q);
	assign diff_mag = diff[DW-1] ? DW'(-diff) : DW'(diff);

	// One restoring division step.
	assign trial    = {rem_q, quo_q[DW-1]};
	assign sub_ok   = (trial >= {1'b0, divisor_q});
	assign quo_next = {quo_q[DW-2:0], sub_ok};
	assign rem_next = sub_ok ? DVW'(trial - {1'b0, divisor_q}) : trial[DVW-1:0];

	// Step the quotient and remainder of |d|*j/(g+1) from j to j+1.
	assign acc_r_sum = {1'b0, acc_r_q} + {1'b0, rem_q};
	assign acc_carry = (acc_r_sum >= {1'b0, divisor_q});

	// Interpolated value from the current accumulator.
	assign interp_sum = neg_q ? (XW'(left_value_q) - XW'({1'b0, acc_q}))
	                          : (XW'(left_value_q) + XW'({1'b0, acc_q}));

	// Next state and the result offered in each emitting state.
	always_comb begin
		state_d    = state_q;
		emit       = 1'b0;
		res_value  = left_value_q;
		res_filled = 1'b1;
		res_ovf    = 1'b0;
		res_last   = 1'b0;
		res_done   = 1'b0;
		unique case (state_q)
			sgf_pkg::ST_IDLE: begin
				if (accept) begin
					if (sample_in.sample_valid) begin
						if (pending_q == '0) begin
							state_d = sgf_pkg::ST_ORIG;
						end else if (!left_known_q) begin
							state_d = sgf_pkg::ST_FILL;
						end else begin
							state_d = sgf_pkg::ST_DIV;
						end
					end else if (gap_full) begin
						state_d = sgf_pkg::ST_OVF;
					end else if (sample_in.series_end) begin
						state_d = sgf_pkg::ST_TAIL;
					end
				end
			end
			sgf_pkg::ST_DIV: begin
				if (div_cnt_q == CW'(1)) begin
					state_d = sgf_pkg::ST_FILL;
				end
			end
			sgf_pkg::ST_FILL: begin
				emit      = 1'b1;
				res_value = interp_q ? interp_sum[SAMPLE_BITS-1:0] : item_value_q;
				if (load && cnt_q == GW'(1)) begin
					state_d = sgf_pkg::ST_ORIG;
				end
			end
			sgf_pkg::ST_ORIG: begin
				emit       = 1'b1;
				res_value  = item_value_q;
				res_filled = 1'b0;
				res_last   = 1'b1;
				res_done   = item_end_q;
				if (load) begin
					state_d = sgf_pkg::ST_IDLE;
				end
			end
			sgf_pkg::ST_OVF: begin
				emit     = 1'b1;
				res_ovf  = 1'b1;
				res_last = (cnt_q == GW'(1)) && !item_end_q;
				if (load && cnt_q == GW'(1)) begin
					state_d = item_end_q ? sgf_pkg::ST_TAIL : sgf_pkg::ST_IDLE;
				end
			end
			sgf_pkg::ST_TAIL: begin
				emit     = 1'b1;
				res_last = (cnt_q == GW'(1));
				res_done = (cnt_q == GW'(1));
				if (load && cnt_q == GW'(1)) begin
					state_d = sgf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sgf_pkg::ST_IDLE;
			end
		endcase
	end

	// A result moves into the output stage when the stage is free or draining.
	assign load = emit && (!out_valid_q || fill_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sgf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Series state, run counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_value_q <= '0;
			left_known_q <= 1'b0;
			pending_q    <= '0;
			cnt_q        <= '0;
			div_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				div_cnt_q <= CW'(DW);
				if (sample_in.sample_valid) begin
					cnt_q     <= pending_q;
					pending_q <= '0;
				end else if (gap_full) begin
					cnt_q     <= GW'(MAX_GAP);
					pending_q <= GW'(1);
				end else begin
					cnt_q     <= GW'(pending_q + 1'b1);
					pending_q <= GW'(pending_q + 1'b1);
				end
			end
			if (state_q == sgf_pkg::ST_DIV) begin
				div_cnt_q <= CW'(div_cnt_q - 1'b1);
			end
			if (load) begin
				// An overflow flush that ends a series leaves one held position for the tail.
				if (state_q == sgf_pkg::ST_OVF && cnt_q == GW'(1)) begin
					cnt_q <= GW'(1);
				end else begin
					cnt_q <= GW'(cnt_q - 1'b1);
				end
				// The series closes on its last result; else the sample becomes the left side.
				if ((state_q == sgf_pkg::ST_ORIG && item_end_q) ||
				    (state_q == sgf_pkg::ST_TAIL && cnt_q == GW'(1))) begin
					left_value_q <= '0;
					left_known_q <= 1'b0;
					pending_q    <= '0;
				end else if (state_q == sgf_pkg::ST_ORIG) begin
					left_value_q <= item_value_q;
					left_known_q <= 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (fill_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture, divider, accumulator and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_value_q <= sample_in.sample_value;
			item_end_q   <= sample_in.series_end;
			interp_q     <= left_known_q;
			neg_q        <= diff[DW-1];
			quo_q        <= diff_mag;
			rem_q        <= '0;
			divisor_q    <= DVW'(pending_q) + DVW'(1);
		end
		if (state_q == sgf_pkg::ST_DIV) begin
			quo_q <= quo_next;
			rem_q <= rem_next;
			if (div_cnt_q == CW'(1)) begin
				acc_q   <= quo_next;
				acc_r_q <= rem_next;
			end
		end
		if (load && state_q == sgf_pkg::ST_FILL) begin
			acc_q   <= DW'(acc_q + quo_q + DW'(acc_carry));
			acc_r_q <= acc_carry ? DVW'(acc_r_sum - {1'b0, divisor_q}) : acc_r_sum[DVW-1:0];
		end
		if (load) begin
			out_value_q  <= res_value;
			out_filled_q <= res_filled;
			out_ovf_q    <= res_ovf;
			out_last_q   <= res_last;
			out_done_q   <= res_done;
		end
	end

	assign fill_out.valid        = out_valid_q;
	assign fill_out.filled_value = out_value_q;
	assign fill_out.was_filled   = out_filled_q;
	assign fill_out.gap_overflow = out_ovf_q;
	assign fill_out.run_last     = out_last_q;
	assign fill_out.series_done  = out_done_q;

endmodule

`default_nettype wire
